[hdl/msl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-channel slew limiter package
// Shared beat formats, table entry layout, operation codes and constants.
// ----------------------------------------------------------------------------
package msl_pkg;

  localparam int ENTRY_COUNT_DEF = 16;
  localparam int MAX_REPORTS     = 16;
  localparam int REP_W           = 5;

  localparam int POS_W  = 16;
  localparam int STEP_W = 15;
  localparam int TAG_W  = 8;
  localparam int IDX_W  = 4;
  localparam int OP_W   = 3;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_SET_CUR = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_TGT = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_TAG = 3'd2;
  localparam logic [OP_W-1:0] OP_AUTO    = 3'd3;
  localparam logic [OP_W-1:0] OP_MANUAL  = 3'd4;
  localparam logic [OP_W-1:0] OP_SINGLE  = 3'd5;

  // Division by 20 is done as a drop of two bits followed by a multiply
  // with the reciprocal of 5 in 18 fractional bits, exact for 14-bit values.
  localparam int          DIV5_W     = 14;
  localparam int          RECIP_SHFT = 18;
  localparam int          PROD_W     = 30;
  localparam int          QUOT_W     = PROD_W - RECIP_SHFT;
  localparam logic [15:0] RECIP5     = 16'd52429;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [IDX_W-1:0]         entry_index;
    logic [TAG_W-1:0]         channel_tag;
    logic signed [POS_W-1:0]  position_value;
    logic [STEP_W-1:0]        step_size;
  } msl_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]         entry_number;
    logic signed [POS_W-1:0]  position_now;
    logic                     reached;
    logic                     last_of_run;
  } msl_out_t;

  typedef struct packed {
    logic [TAG_W-1:0]         tag;
    logic signed [POS_W-1:0]  target;
    logic signed [POS_W-1:0]  current;
  } msl_entry_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  position;
    logic                     reached;
  } msl_move_t;

endpackage
`default_nettype wire

[hdl/msl_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Entry table
// Synchronous single-port-write, registered-read memory of table entries,
// with one valid bit per entry so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module msl_table #(
  parameter int ENTRY_COUNT = msl_pkg::ENTRY_COUNT_DEF,
  parameter int AW          = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [AW-1:0]        rd_addr,
  output msl_pkg::msl_entry_t  rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  msl_pkg::msl_entry_t  wr_data
);
  import msl_pkg::*;

  msl_entry_t             mem [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] valid;
  msl_entry_t             rd_q;
  logic                   rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[rd_addr];
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule
`default_nettype wire

[hdl/msl_mover.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Position mover
// Moves a current position toward its target by at most one step and
// snaps to the target when it lies within that step.
// ----------------------------------------------------------------------------
module msl_mover (
  input  logic signed [msl_pkg::POS_W-1:0] current,
  input  logic signed [msl_pkg::POS_W-1:0] target,
  input  logic [msl_pkg::STEP_W-1:0]       step,
  output msl_pkg::msl_move_t               result
);
  import msl_pkg::*;

  localparam int XW = POS_W + 2;

  logic signed [XW-1:0] cur_x;
  logic signed [XW-1:0] tgt_x;
  logic signed [XW-1:0] step_x;
  logic signed [XW-1:0] up;
  logic signed [XW-1:0] down;

  always_comb begin
    cur_x  = XW'(current);
    tgt_x  = XW'(target);
    step_x = signed'({3'b000, step});
    up     = cur_x + step_x;
    down   = cur_x - step_x;
    if (tgt_x > up) begin
      result.position = up[POS_W-1:0];
      result.reached  = 1'b0;
    end else if (tgt_x < down) begin
      result.position = down[POS_W-1:0];
      result.reached  = 1'b0;
    end else begin
      result.position = target;
      result.reached  = 1'b1;
    end
  end

endmodule
`default_nettype wire

[hdl/multi_channel_slew_limiter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-channel slew limiter
// Table of positions that are stepped toward their targets, per channel or
// per entry, with one result beat for each entry that a damp moves, up to 16.
// ----------------------------------------------------------------------------
// The table lives in one registered-read memory; each input beat is handled
// by a small sequencer that reads an entry, works on it and writes it back.
// A set beat reads its entry and writes back the merged field. A single damp
// reads, loads the entry and its distance, sets the step size, moves and
// writes back, then hands its result over. A channel damp walks every entry
// in order: an entry on another channel is read and compared, a matching
// entry is read, loaded with its distance, given its step size, moved and
// written back; a flush step closes the run. The steps follow from the one
// memory port and the divide-by-20 multiply's own stage. Each result is held
// one match back so that the final one can carry last_of_run; the walk waits
// only when that held result cannot move into the output register. An input
// beat may be accepted while the last result still waits in the output
// register. Set beats and out-of-range or unused codes give no result beat.
// After reset every entry reads as zero, with no clearing pass. With more
// than 16 entries all matching entries are still moved, but only the first
// 16 are reported, and entry_number is the low four bits of the index.
// ----------------------------------------------------------------------------
module multi_channel_slew_limiter #(
  parameter int ENTRY_COUNT = msl_pkg::ENTRY_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  msl_pkg::msl_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output msl_pkg::msl_out_t  out_data
);
  import msl_pkg::*;

  localparam int AW   = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int LAST = ENTRY_COUNT - 1;
  localparam int CW   = 7;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_LOAD  = 6'b000100,
    S_DIV   = 6'b001000,
    S_MOVE  = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  state_t             state;
  state_t             state_next;
  msl_in_t            cmd;
  logic [AW-1:0]      addr;
  msl_entry_t         ent;
  logic [POS_W-1:0]   abs_diff;
  logic [STEP_W-1:0]  step;
  msl_out_t           hold;
  logic               hold_valid;
  logic [REP_W-1:0]   rep_count;

  msl_entry_t         rd_data;
  msl_entry_t         wr_data;
  logic               wr_en;
  msl_move_t          mv;

  logic               start;
  logic               idx_ok;
  logic               is_chan;
  logic               is_set;
  logic               tag_hit;
  logic               last_addr;
  logic               report;
  logic               out_free;
  logic               move_go;
  logic               out_load;
  logic signed [POS_W:0] diff;
  logic [PROD_W-1:0]  prod;

  msl_table #(
    .ENTRY_COUNT (ENTRY_COUNT),
    .AW          (AW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (wr_data)
  );

  msl_mover u_mover (
    .current (ent.current),
    .target  (ent.target),
    .step    (step),
    .result  (mv)
  );

  assign in_ready = (state == S_IDLE);

  always_comb begin
    idx_ok    = CW'(in_data.entry_index) < CW'(ENTRY_COUNT);
    is_chan   = (cmd.operation == OP_AUTO) || (cmd.operation == OP_MANUAL);
    is_set    = (cmd.operation == OP_SET_CUR) || (cmd.operation == OP_SET_TGT) ||
                (cmd.operation == OP_SET_TAG);
    tag_hit   = (rd_data.tag == cmd.channel_tag);
    last_addr = (addr == AW'(LAST));
    report    = rep_count < REP_W'(MAX_REPORTS);
    out_free  = !out_valid || out_ready;
    // The walk may only step past an entry once the held result has a place.
    move_go   = !(report && hold_valid && !out_free);
    // A held result moves into the output register in these two places.
    out_load  = ((state == S_MOVE) && move_go && report && hold_valid) ||
                ((state == S_FLUSH) && hold_valid && out_free);

    // Distance of the entry just read, and the divide-by-20 quotient of the
    // registered distance for auto damp.
    diff = (POS_W+1)'(rd_data.target) - (POS_W+1)'(rd_data.current);
    prod = PROD_W'(abs_diff[POS_W-1:2]) * PROD_W'(RECIP5);

    case (in_data.operation) inside
      OP_SET_CUR, OP_SET_TGT, OP_SET_TAG, OP_SINGLE: start = idx_ok;
      OP_AUTO, OP_MANUAL:                            start = 1'b1;
      default:                                       start = 1'b0;
    endcase
  end

  // Write-back data: a merged entry for set beats, the moved entry otherwise.
  always_comb begin
    wr_en   = 1'b0;
    wr_data = rd_data;
    if (state == S_LOAD && is_set) begin
      wr_en = 1'b1;
      case (cmd.operation)
        OP_SET_CUR: wr_data.current = cmd.position_value;
        OP_SET_TGT: wr_data.target  = cmd.position_value;
        default:    wr_data.tag     = cmd.channel_tag;
      endcase
    end else if (state == S_MOVE && move_go) begin
      wr_en           = 1'b1;
      wr_data.tag     = ent.tag;
      wr_data.target  = ent.target;
      wr_data.current = mv.position;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && start) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (is_set) begin
          state_next = S_IDLE;
        end else if (is_chan && !tag_hit) begin
          state_next = last_addr ? S_FLUSH : S_READ;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        state_next = S_MOVE;
      end
      S_MOVE: begin
        if (move_go) state_next = (is_chan && !last_addr) ? S_READ : S_FLUSH;
      end
      S_FLUSH: begin
        if (!hold_valid || out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
      rep_count  <= '0;
      addr       <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd        <= in_data;
            hold_valid <= 1'b0;
            rep_count  <= '0;
            if (in_data.operation == OP_AUTO || in_data.operation == OP_MANUAL) begin
              addr <= '0;
            end else if (start) begin
              addr <= AW'(in_data.entry_index);
            end
          end
        end
        S_READ: begin
        end
        S_LOAD: begin
          ent      <= rd_data;
          abs_diff <= diff[POS_W] ? POS_W'(-diff) : diff[POS_W-1:0];
          if (is_chan && !tag_hit && !last_addr) begin
            addr <= addr + AW'(1);
          end
        end
        S_DIV: begin
          if (cmd.operation == OP_AUTO) begin
            step <= STEP_W'(prod[PROD_W-1:RECIP_SHFT]) + STEP_W'(1);
          end else begin
            step <= cmd.step_size;
          end
        end
        S_MOVE: begin
          if (move_go) begin
            if (report) begin
              if (hold_valid) begin
                out_data <= hold;
              end
              hold.entry_number <= IDX_W'(addr);
              hold.position_now <= mv.position;
              hold.reached      <= mv.reached;
              hold.last_of_run  <= 1'b0;
              hold_valid        <= 1'b1;
              rep_count         <= rep_count + REP_W'(1);
            end
            if (is_chan && !last_addr) begin
              addr <= addr + AW'(1);
            end
          end
        end
        S_FLUSH: begin
          if (hold_valid && out_free) begin
            out_data   <= '{hold.entry_number, hold.position_now, hold.reached, 1'b1};
            hold_valid <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire
